### rtl/core/assert_macros.svh
// Assertion macros shared by the averager RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define FCA_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fca: same-cycle implication failed");

// Next-cycle implication, checked only out of reset.
`define FCA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fca: next-cycle implication failed");

`endif

### rtl/core/fca_pkg.sv
// Shared types and fixed constants of the flagged channel averager.
// No dependencies; used by the controller, datapath and top level.
package fca_pkg;

	// fixed field widths
	localparam int FREQ_W      = 40;
	localparam int AVG_W       = 5;
	localparam int NPOL_W      = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int PASS_LIMIT  = 2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_AVERAGING = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_POLS  = 2'd1;

	// reset values of the registers
	localparam logic [AVG_W-1:0]  AVG_RESET  = 5'd1;
	localparam logic [NPOL_W-1:0] NPOL_RESET = 3'd4;

	// divider operand select
	typedef enum logic [1:0] {
		DIV_SEL_RE = 2'd0,
		DIV_SEL_IM = 2'd1,
		DIV_SEL_FQ = 2'd2
	} div_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     item_load;
		logic     exec;
		logic     div_start;
		div_sel_t div_sel;
		logic     cap_re;
		logic     cap_im;
		logic     cap_fq;
		logic     res_flag;
		logic     out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pass;
		logic kind;
		logic grp_end;
		logic all_flagged;
		logic div_done;
	} status_t;

endpackage

### rtl/core/fca_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by the datapath. Uses assert_macros.svh.
`include "assert_macros.svh"

module fca_div #(
	parameter int DW = 44,
	parameter int CW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNTW = $clog2(DW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   dvs_q;
	logic [DW-1:0]   quo_q;

	logic [CW:0] trial;
	logic        ge;
	logic [CW:0] diff;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// control: busy while the DW quotient bits shift in, done pulses the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands: quotient shifts in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	// a new division never cuts into a running one
	`FCA_ASSERT_IMPL(a_no_restart, start, !busy_q)

endmodule

### rtl/core/fca_datapath.sv
// Datapath: config registers, per-pol accumulators, divider, result and output regs.
// Depends on fca_pkg and fca_div.
module fca_datapath #(
	parameter int MAX_POLS      = 4,
	parameter int MAX_AVERAGING = 16,
	parameter int SAMPLE_WIDTH  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fca_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fca_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  fca_pkg::cmd_t                    cmd,
	output fca_pkg::status_t                 st,
	input  logic                             kind,
	input  logic signed [SAMPLE_WIDTH-1:0]   vis_real,
	input  logic signed [SAMPLE_WIDTH-1:0]   vis_imag,
	input  logic                             flagged,
	input  logic [fca_pkg::FREQ_W-1:0]       freq_value,
	output logic                             out_kind,
	output logic signed [SAMPLE_WIDTH-1:0]   avg_real,
	output logic signed [SAMPLE_WIDTH-1:0]   avg_imag,
	output logic                             avg_flagged,
	output logic [fca_pkg::FREQ_W-1:0]       avg_freq
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int FW   = fca_pkg::FREQ_W;
	localparam int GW   = $clog2(MAX_AVERAGING);
	localparam int CW   = $clog2(MAX_AVERAGING + 1);
	localparam int SUMW = SW + GW;
	localparam int FSW  = FW + GW;
	localparam int DW   = (SUMW > FSW) ? SUMW : FSW;
	localparam int PW   = (MAX_POLS > 1) ? $clog2(MAX_POLS) : 1;
	localparam int NW   = $clog2(MAX_POLS + 1);

	// configuration
	logic [fca_pkg::AVG_W-1:0]  avg_cfg_q;
	logic [fca_pkg::NPOL_W-1:0] npol_cfg_q;
	logic                       cfg_hit;

	assign cfg_hit = cfg_wr_en &&
		(cfg_index == fca_pkg::REG_AVERAGING || cfg_index == fca_pkg::REG_NUM_POLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_cfg_q  <= fca_pkg::AVG_RESET;
			npol_cfg_q <= fca_pkg::NPOL_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fca_pkg::REG_AVERAGING: avg_cfg_q  <= cfg_data[fca_pkg::AVG_W-1:0];
				fca_pkg::REG_NUM_POLS:  npol_cfg_q <= cfg_data[fca_pkg::NPOL_W-1:0];
				default: ;
			endcase
		end
	end

	// effective group size and pol count
	logic [CW-1:0] avg_eff;
	logic [NW-1:0] npol_eff;
	logic          pass_w;

	always_comb begin
		if (32'(avg_cfg_q) > 32'(MAX_AVERAGING))
			avg_eff = CW'(MAX_AVERAGING);
		else
			avg_eff = CW'(avg_cfg_q);
		if (npol_cfg_q == '0)
			npol_eff = NW'(1);
		else if (32'(npol_cfg_q) > 32'(MAX_POLS))
			npol_eff = NW'(MAX_POLS);
		else
			npol_eff = NW'(npol_cfg_q);
		pass_w = avg_eff < CW'(fca_pkg::PASS_LIMIT);
	end

	// captured input beat
	logic                 kind_q;
	logic signed [SW-1:0] re_q;
	logic signed [SW-1:0] im_q;
	logic                 flg_q;
	logic [FW-1:0]        freq_q;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q <= kind;
			re_q   <= vis_real;
			im_q   <= vis_imag;
			flg_q  <= flagged;
			freq_q <= freq_value;
		end
	end

	// accumulator state
	logic signed [SUMW-1:0] sum_re_q [MAX_POLS];
	logic signed [SUMW-1:0] sum_im_q [MAX_POLS];
	logic [CW-1:0]          cnt_q    [MAX_POLS];
	logic [PW-1:0]          pol_q;
	logic [GW-1:0]          vgrp_q;
	logic [FSW-1:0]         fsum_q;
	logic [GW-1:0]          fgrp_q;

	// operands handed to the divider at a group end
	logic signed [SUMW-1:0] op_re_q;
	logic signed [SUMW-1:0] op_im_q;
	logic [CW-1:0]          op_cnt_q;
	logic [FSW-1:0]         op_fq_q;

	// next accumulator values for the current beat
	logic [PW-1:0]          p;
	logic                   last_pol;
	logic                   vend;
	logic                   fend;
	logic signed [SUMW-1:0] new_re;
	logic signed [SUMW-1:0] new_im;
	logic [CW-1:0]          new_cnt;
	logic [FSW-1:0]         new_fsum;

	always_comb begin
		if (NW'(pol_q) >= npol_eff)
			p = PW'(npol_eff - NW'(1));
		else
			p = pol_q;
		last_pol = ((NW+1)'(p) + (NW+1)'(1)) >= (NW+1)'(npol_eff);
		vend     = ((CW+1)'(vgrp_q) + (CW+1)'(1)) >= (CW+1)'(avg_eff);
		fend     = ((CW+1)'(fgrp_q) + (CW+1)'(1)) >= (CW+1)'(avg_eff);
		new_re   = sum_re_q[p];
		new_im   = sum_im_q[p];
		new_cnt  = cnt_q[p];
		if (!flg_q) begin
			new_re  = sum_re_q[p] + SUMW'(re_q);
			new_im  = sum_im_q[p] + SUMW'(im_q);
			new_cnt = cnt_q[p] + CW'(1);
		end
		new_fsum = fsum_q + FSW'(freq_q);
	end

	// accumulate; a group end clears the sums (the operand regs below load them on every exec)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_POLS; i++) begin
				sum_re_q[i] <= '0;
				sum_im_q[i] <= '0;
				cnt_q[i]    <= '0;
			end
			pol_q  <= '0;
			vgrp_q <= '0;
			fsum_q <= '0;
			fgrp_q <= '0;
		end else if (cfg_hit) begin
			for (int i = 0; i < MAX_POLS; i++) begin
				sum_re_q[i] <= '0;
				sum_im_q[i] <= '0;
				cnt_q[i]    <= '0;
			end
			pol_q  <= '0;
			vgrp_q <= '0;
			fsum_q <= '0;
			fgrp_q <= '0;
		end else if (cmd.exec && !pass_w) begin
			if (kind_q) begin
				if (fend) begin
					fsum_q <= '0;
					fgrp_q <= '0;
				end else begin
					fsum_q <= new_fsum;
					fgrp_q <= fgrp_q + GW'(1);
				end
			end else begin
				if (vend) begin
					sum_re_q[p] <= '0;
					sum_im_q[p] <= '0;
					cnt_q[p]    <= '0;
				end else begin
					sum_re_q[p] <= new_re;
					sum_im_q[p] <= new_im;
					cnt_q[p]    <= new_cnt;
				end
				if (last_pol) begin
					pol_q  <= '0;
					vgrp_q <= vend ? '0 : vgrp_q + GW'(1);
				end else begin
					pol_q <= p + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			op_re_q  <= new_re;
			op_im_q  <= new_im;
			op_cnt_q <= new_cnt;
			op_fq_q  <= new_fsum;
		end
	end

	// divider operand select, magnitudes for the signed sums
	logic [SUMW-1:0] mag_re;
	logic [SUMW-1:0] mag_im;
	logic [DW-1:0]   div_dvd;
	logic [CW-1:0]   div_dvs;
	logic            div_done;
	logic [DW-1:0]   div_quo;

	always_comb begin
		mag_re = op_re_q[SUMW-1] ? SUMW'(-op_re_q) : SUMW'(op_re_q);
		mag_im = op_im_q[SUMW-1] ? SUMW'(-op_im_q) : SUMW'(op_im_q);
		case (cmd.div_sel)
			fca_pkg::DIV_SEL_RE: begin
				div_dvd = DW'(mag_re);
				div_dvs = op_cnt_q;
			end
			fca_pkg::DIV_SEL_IM: begin
				div_dvd = DW'(mag_im);
				div_dvs = op_cnt_q;
			end
			fca_pkg::DIV_SEL_FQ: begin
				div_dvd = DW'(op_fq_q);
				div_dvs = avg_eff;
			end
			default: begin
				div_dvd = '0;
				div_dvs = '0;
			end
		endcase
	end

	fca_div #(
		.DW(DW),
		.CW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// quotient with the sign of the sum, truncated toward zero
	logic [SW-1:0] q_low;
	logic [SW-1:0] q_re;
	logic [SW-1:0] q_im;

	always_comb begin
		q_low = div_quo[SW-1:0];
		q_re  = op_re_q[SUMW-1] ? (~q_low + SW'(1)) : q_low;
		q_im  = op_im_q[SUMW-1] ? (~q_low + SW'(1)) : q_low;
	end

	// result register
	logic                 res_kind_q;
	logic signed [SW-1:0] res_re_q;
	logic signed [SW-1:0] res_im_q;
	logic                 res_flg_q;
	logic [FW-1:0]        res_fq_q;

	always_ff @(posedge clk) begin
		if (cmd.exec && pass_w) begin
			res_kind_q <= kind_q;
			res_re_q   <= kind_q ? '0 : re_q;
			res_im_q   <= kind_q ? '0 : im_q;
			res_flg_q  <= kind_q ? 1'b0 : flg_q;
			res_fq_q   <= kind_q ? freq_q : '0;
		end
		if (cmd.res_flag) begin
			res_kind_q <= 1'b0;
			res_re_q   <= '0;
			res_im_q   <= '0;
			res_flg_q  <= 1'b1;
			res_fq_q   <= '0;
		end
		if (cmd.cap_re) begin
			res_kind_q <= 1'b0;
			res_re_q   <= q_re;
			res_flg_q  <= 1'b0;
			res_fq_q   <= '0;
		end
		if (cmd.cap_im)
			res_im_q <= q_im;
		if (cmd.cap_fq) begin
			res_kind_q <= 1'b1;
			res_re_q   <= '0;
			res_im_q   <= '0;
			res_flg_q  <= 1'b0;
			res_fq_q   <= div_quo[FW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_kind    <= res_kind_q;
			avg_real    <= res_re_q;
			avg_imag    <= res_im_q;
			avg_flagged <= res_flg_q;
			avg_freq    <= res_fq_q;
		end
	end

	// status to the controller
	always_comb begin
		st.pass        = pass_w;
		st.kind        = kind_q;
		st.grp_end     = kind_q ? fend : vend;
		st.all_flagged = (op_cnt_q == '0);
		st.div_done    = div_done;
	end

endmodule

### rtl/core/fca_ctrl.sv
// Controller: sequences one beat through accumulate, divide and output.
// Depends on fca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fca_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  fca_pkg::status_t st,
	output fca_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_LOAD   = 7'b0000100,
		S_DIV_RE = 7'b0001000,
		S_DIV_IM = 7'b0010000,
		S_DIV_FQ = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = fca_pkg::DIV_SEL_RE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (st.pass)
					state_d = S_OUT;
				else if (st.grp_end)
					state_d = S_LOAD;
				else
					state_d = S_IDLE;
			end
			S_LOAD: begin
				if (st.kind) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = fca_pkg::DIV_SEL_FQ;
					state_d       = S_DIV_FQ;
				end else if (st.all_flagged) begin
					cmd.res_flag = 1'b1;
					state_d      = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = fca_pkg::DIV_SEL_RE;
					state_d       = S_DIV_RE;
				end
			end
			S_DIV_RE: begin
				if (st.div_done) begin
					cmd.cap_re    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = fca_pkg::DIV_SEL_IM;
					state_d       = S_DIV_IM;
				end
			end
			S_DIV_IM: begin
				cmd.div_sel = fca_pkg::DIV_SEL_IM;
				if (st.div_done) begin
					cmd.cap_im = 1'b1;
					state_d    = S_OUT;
				end
			end
			S_DIV_FQ: begin
				cmd.div_sel = fca_pkg::DIV_SEL_FQ;
				if (st.div_done) begin
					cmd.cap_fq = 1'b1;
					state_d    = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// an accepted beat always goes through the accumulate step
	`FCA_ASSERT_NEXT(a_accept_to_exec, in_valid && !in_stall, state_q == S_EXEC)
	// a result only appears after the output step
	`FCA_ASSERT_IMPL(a_out_from_out_state, $rose(out_valid_q), $past(state_q) == S_OUT)
	// divider completions land only in a divide state
	`FCA_ASSERT_IMPL(a_done_in_div, st.div_done,
		state_q == S_DIV_RE || state_q == S_DIV_IM || state_q == S_DIV_FQ)

endmodule

### rtl/core/flagged_channel_averager.sv
// Top level of the flagged channel averager: controller plus datapath.
// Depends on fca_pkg, fca_ctrl, fca_datapath (and fca_div below it).
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    kind, vis_real, vis_imag, flagged, freq_value
// output    out        out_valid/out_stall  out_kind, avg_real, avg_imag, avg_flagged, avg_freq
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// One beat at a time. Every beat is loaded, and all but passthrough beats accumulated; a passthrough
// beat then goes to output, a fully flagged group end to the load step and output. Group ends run the
// shared bit-serial divider of DW = max(SAMPLE_WIDTH, 40) + log2(MAX_AVERAGING) bits
// (44 by default), once for a frequency beat, twice (real, then imag) for a visibility one not fully flagged.
// Reset: registers to averaging 1, num_pols 4, accumulators cleared; no clearing pass.
// A held result sits in the output register; a stalled output holds the next result back, and the input with it.
module flagged_channel_averager #(
	parameter int MAX_POLS      = 4,
	parameter int MAX_AVERAGING = 16,
	parameter int SAMPLE_WIDTH  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fca_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fca_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic signed [SAMPLE_WIDTH-1:0]   vis_real,
	input  logic signed [SAMPLE_WIDTH-1:0]   vis_imag,
	input  logic                             flagged,
	input  logic [fca_pkg::FREQ_W-1:0]       freq_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             out_kind,
	output logic signed [SAMPLE_WIDTH-1:0]   avg_real,
	output logic signed [SAMPLE_WIDTH-1:0]   avg_imag,
	output logic                             avg_flagged,
	output logic [fca_pkg::FREQ_W-1:0]       avg_freq
);

	fca_pkg::cmd_t    cmd;
	fca_pkg::status_t st;

	fca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	fca_datapath #(
		.MAX_POLS      (MAX_POLS),
		.MAX_AVERAGING (MAX_AVERAGING),
		.SAMPLE_WIDTH  (SAMPLE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.st          (st),
		.kind        (kind),
		.vis_real    (vis_real),
		.vis_imag    (vis_imag),
		.flagged     (flagged),
		.freq_value  (freq_value),
		.out_kind    (out_kind),
		.avg_real    (avg_real),
		.avg_imag    (avg_imag),
		.avg_flagged (avg_flagged),
		.avg_freq    (avg_freq)
	);

endmodule
